@@ rtl/core/ssd_pkg.sv @@
// shared types, constants and glyph table for the seven-segment formatter
`default_nettype none

package ssd_pkg;

    localparam int NUMBER_W   = 28;
    localparam int MAX_DIGITS = 8;
    localparam int POS_W      = 3;
    localparam int COUNT_W    = 4;
    localparam int SEG_W      = 8;
    localparam int REM_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // reciprocal of ten, exact for any dividend below 2^32 with a 35-bit shift
    localparam int RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;
    localparam int PROD_W      = NUMBER_W + RECIP_W;

    localparam logic [COUNT_W-1:0] DIGITS_MAX = COUNT_W'(MAX_DIGITS);
    localparam logic [COUNT_W-1:0] DIGITS_RESET = 4'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIGIT_COUNT  = 2'd0,
        CFG_COMMON_ANODE = 2'd1,
        CFG_ZERO_FILL    = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_SIGN = 3'b100
    } state_t;

    // result of the shared divide-by-ten unit
    typedef struct packed {
        logic [NUMBER_W-1:0] quot;
        logic [REM_W-1:0]    rem;
    } div_res_t;

    localparam logic [SEG_W-1:0] GLYPH_MINUS = 8'h02;
    localparam logic [SEG_W-1:0] GLYPH_BLANK = 8'h00;
    localparam logic [SEG_W-1:0] GLYPH_ZERO  = 8'hFC;

    // a..g in bits 7..1, point off
    function automatic logic [SEG_W-1:0] digit_glyph(input logic [REM_W-1:0] d);
        logic [SEG_W-1:0] g;
        case (d)
            4'd0:    g = 8'hFC;
            4'd1:    g = 8'h60;
            4'd2:    g = 8'hDA;
            4'd3:    g = 8'hF2;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'hB6;
            4'd6:    g = 8'hBE;
            4'd7:    g = 8'hE0;
            4'd8:    g = 8'hFE;
            4'd9:    g = 8'hF6;
            default: g = GLYPH_BLANK;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/signed_decimal_seven_segment_formatter.sv @@
// top level: config registers, digit sequencer and output beat register
`default_nettype none

// Takes one signed 28-bit value per input beat and returns one segment byte
// per display position in use (digit_count, clamped to 1..8), rightmost
// position first and position 0 last, flagged by m_last. After the input beat
// is taken, the sequencer peels off one decimal digit per cycle through a
// single shared divide-by-ten unit (reciprocal multiply), so a value with n
// positions produces n beats at one beat per cycle when the output side does
// not stall; s_ready returns in the cycle in which the final beat first shows
// in the output register. Config writes are taken whenever the block is out
// of reset (cfg_ready follows aresetn) and are meant to happen while the
// block is idle. Both ready outputs stay low during reset.

module signed_decimal_seven_segment_formatter (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [ssd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ssd_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  wire logic                               s_valid,
    output      logic                               s_ready,
    input  wire logic signed [ssd_pkg::NUMBER_W-1:0] s_number,

    output      logic                               m_valid,
    input  wire logic                               m_ready,
    output      logic [ssd_pkg::POS_W-1:0]          m_position,
    output      logic [ssd_pkg::SEG_W-1:0]          m_segments,
    output      logic                               m_last
);

    // config registers
    logic [ssd_pkg::COUNT_W-1:0] digit_count_reg;
    logic                        common_anode_reg;
    logic                        zero_fill_reg;

    // sequencer state
    ssd_pkg::state_t              state_reg, state_next;
    logic [ssd_pkg::NUMBER_W-1:0] mag_reg, mag_next;
    logic                         neg_reg, neg_next;    // minus still to place
    logic                         lead_reg, lead_next;  // minus pinned at position 0
    logic                         first_reg, first_next;
    logic [ssd_pkg::POS_W-1:0]    pos_reg, pos_next;

    // output beat register
    logic                         m_valid_reg, m_valid_next;
    logic [ssd_pkg::POS_W-1:0]    m_position_reg, m_position_next;
    logic [ssd_pkg::SEG_W-1:0]    m_segments_reg, m_segments_next;

    logic [ssd_pkg::COUNT_W-1:0]  n_eff;
    logic [ssd_pkg::NUMBER_W-1:0] raw;
    logic [ssd_pkg::NUMBER_W-1:0] mag_in;
    logic                         neg_in;
    logic                         slot_free;
    logic                         last_digit;
    logic [ssd_pkg::SEG_W-1:0]    glyph;
    ssd_pkg::div_res_t            div_res;

    // writes are dropped while in reset, so ready stays low there
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg  <= ssd_pkg::DIGITS_RESET;
            common_anode_reg <= 1'b0;
            zero_fill_reg    <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                ssd_pkg::CFG_DIGIT_COUNT:  digit_count_reg  <= cfg_data;
                ssd_pkg::CFG_COMMON_ANODE: common_anode_reg <= cfg_data[0];
                ssd_pkg::CFG_ZERO_FILL:    zero_fill_reg    <= cfg_data[0];
                default: ;  // unmapped index, write ignored
            endcase
        end
    end

    // positions in use: zero reads as one, saturate at the digit limit
    always_comb begin
        if (digit_count_reg == '0) begin
            n_eff = ssd_pkg::COUNT_W'(1);
        end else if (digit_count_reg > ssd_pkg::DIGITS_MAX) begin
            n_eff = ssd_pkg::DIGITS_MAX;
        end else begin
            n_eff = digit_count_reg;
        end
    end

    // magnitude of the two's complement input, most negative value included
    assign raw    = s_number;
    assign neg_in = raw[ssd_pkg::NUMBER_W-1];
    assign mag_in = neg_in ? (~raw + ssd_pkg::NUMBER_W'(1)) : raw;

    ssd_div10 u_div10 (
        .dividend (mag_reg),
        .result   (div_res)
    );

    assign s_ready    = (state_reg == ssd_pkg::ST_IDLE) && aresetn;
    assign slot_free  = !m_valid_reg || m_ready;
    // lowest digit position is 1 when the minus owns position 0
    assign last_digit = (pos_reg == ssd_pkg::POS_W'(lead_reg));

    // glyph for the current digit slot
    always_comb begin
        if (mag_reg != '0) begin
            glyph = ssd_pkg::digit_glyph(div_res.rem);
        end else if (neg_reg) begin
            glyph = ssd_pkg::GLYPH_MINUS;
        end else if (zero_fill_reg || first_reg) begin
            glyph = ssd_pkg::GLYPH_ZERO;
        end else begin
            glyph = ssd_pkg::GLYPH_BLANK;
        end
    end

    always_comb begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        lead_next       = lead_reg;
        first_next      = first_reg;
        pos_next        = pos_reg;
        m_valid_next    = m_valid_reg;
        m_position_next = m_position_reg;
        m_segments_next = m_segments_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ssd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    mag_next   = mag_in;
                    neg_next   = neg_in && !zero_fill_reg;
                    lead_next  = neg_in && zero_fill_reg;
                    first_next = 1'b1;
                    pos_next   = ssd_pkg::POS_W'(n_eff - ssd_pkg::COUNT_W'(1));
                    // single position with pinned minus: no digit slots at all
                    if (neg_in && zero_fill_reg && n_eff == ssd_pkg::COUNT_W'(1)) begin
                        state_next = ssd_pkg::ST_SIGN;
                    end else begin
                        state_next = ssd_pkg::ST_RUN;
                    end
                end
            end
            ssd_pkg::ST_RUN: begin
                if (slot_free) begin
                    m_valid_next    = 1'b1;
                    m_position_next = pos_reg;
                    m_segments_next = glyph ^ {ssd_pkg::SEG_W{common_anode_reg}};
                    mag_next        = div_res.quot;
                    first_next      = 1'b0;
                    pos_next        = pos_reg - ssd_pkg::POS_W'(1);
                    if (mag_reg == '0 && neg_reg) begin
                        neg_next = 1'b0;
                    end
                    if (last_digit) begin
                        state_next = lead_reg ? ssd_pkg::ST_SIGN : ssd_pkg::ST_IDLE;
                    end
                end
            end
            ssd_pkg::ST_SIGN: begin
                if (slot_free) begin
                    m_valid_next    = 1'b1;
                    m_position_next = '0;
                    m_segments_next = ssd_pkg::GLYPH_MINUS ^ {ssd_pkg::SEG_W{common_anode_reg}};
                    state_next      = ssd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ssd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ssd_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        lead_reg       <= lead_next;
        first_reg      <= first_next;
        pos_reg        <= pos_next;
        m_position_reg <= m_position_next;
        m_segments_reg <= m_segments_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_position = m_position_reg;
    assign m_segments = m_segments_reg;
    assign m_last     = (m_position_reg == '0);

endmodule

`default_nettype wire

@@ rtl/core/ssd_div10.sv @@
// divide-by-ten unit: quotient and remainder by reciprocal multiply
`default_nettype none

module ssd_div10 (
    input  wire logic [ssd_pkg::NUMBER_W-1:0] dividend,
    output ssd_pkg::div_res_t                 result
);

    logic [ssd_pkg::PROD_W-1:0]   prod;
    logic [ssd_pkg::NUMBER_W-1:0] quot;
    logic [ssd_pkg::NUMBER_W-1:0] times_ten;
    logic [ssd_pkg::NUMBER_W-1:0] diff;

    assign prod = ssd_pkg::PROD_W'(dividend) * ssd_pkg::PROD_W'(ssd_pkg::RECIP_TEN);
    assign quot = ssd_pkg::NUMBER_W'(prod >> ssd_pkg::RECIP_SHIFT);

    // q*10 as two shifts and an add
    assign times_ten = (quot << 3) + (quot << 1);
    assign diff      = dividend - times_ten;

    assign result.quot = quot;
    assign result.rem  = diff[ssd_pkg::REM_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/ssd_checker.sv @@
// port-level checker for the seven-segment formatter, with its bind
`default_nettype none

module ssd_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [ssd_pkg::POS_W-1:0]      m_position,
    input wire logic                           m_last
);

    // a stalled beat stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // last flag marks exactly position zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_position == '0)))
        else $error("last flag does not match position zero");

    // no new value taken while a value is still being sent out
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input ready before final beat");

    // a taken value closes the input in the cycle after it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a value was taken");

    // beats walk leftward one position per beat with no gap
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=>
            m_valid && (m_position == $past(m_position) - ssd_pkg::POS_W'(1)))
        else $error("beat sequence broken");

endmodule

bind signed_decimal_seven_segment_formatter ssd_checker u_ssd_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_position (m_position),
    .m_last     (m_last)
);

`default_nettype wire
